/* hdl/display_page_command_parser_assert.svh */
// Assertion macros for the display page command parser checker
`ifndef DISPLAY_PAGE_COMMAND_PARSER_ASSERT_SVH
`define DISPLAY_PAGE_COMMAND_PARSER_ASSERT_SVH

// checked only outside reset
`define DPPC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("dppc assertion failed");

// checked on every edge
`define DPPC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("dppc assertion failed");

`endif

/* hdl/dppc_pkg.sv */
// Package: types, constants and frame table for the display page command parser
package dppc_pkg;

    localparam int BufferDepth = 64;
    localparam int CountW      = 7;

    localparam int QueueDepth  = 2;
    localparam int QPtrW       = $clog2(QueueDepth);
    localparam int QCntW       = $clog2(QueueDepth + 1);

    localparam int FrameLen    = 10;
    localparam int IdxW        = $clog2(FrameLen);
    localparam logic [IdxW-1:0] LastIdx = IdxW'(FrameLen - 1);

    localparam logic [7:0] HeadFirst  = 8'h5A;
    localparam logic [7:0] HeadSecond = 8'hA5;
    localparam logic [7:0] KeyHigh    = 8'h10;
    localparam logic [7:0] KeyPage1   = 8'h02;
    localparam logic [7:0] KeyPage0   = 8'h03;
    localparam logic [7:0] TermPrior  = 8'h01;
    localparam logic [7:0] TermByte   = 8'h00;
    localparam logic [7:0] AsciiO     = 8'd79;
    localparam logic [7:0] AsciiK     = 8'd75;

    typedef struct packed {
        logic valid;
        logic page;
    } t_cmd;

    function automatic logic [7:0] frame_byte(input logic [IdxW-1:0] idx, input logic page);
        logic [7:0] b;
        unique case (idx)
            4'd0:    b = 8'h5A;
            4'd1:    b = 8'hA5;
            4'd2:    b = 8'h07;
            4'd3:    b = 8'h82;
            4'd4:    b = 8'h00;
            4'd5:    b = 8'h84;
            4'd6:    b = 8'h5A;
            4'd7:    b = 8'h01;
            4'd8:    b = 8'h00;
            4'd9:    b = {7'd0, page};
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

/* hdl/dppc_queue.sv */
// Short command queue between the parser front end and the frame sender
module dppc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dppc_pkg::t_cmd  i_push,
    output logic            o_full,
    output dppc_pkg::t_cmd  o_head,
    input  logic            i_pop
);
    logic                          r_mem [dppc_pkg::QueueDepth];
    logic [dppc_pkg::QPtrW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [dppc_pkg::QCntW-1:0]    r_cnt;
    logic                          do_push, do_pop;

    assign o_full       = (r_cnt == dppc_pkg::QCntW'(dppc_pkg::QueueDepth));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.page  = r_mem[r_rd_ptr];
    assign do_push      = i_push.valid && !o_full;
    assign do_pop       = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (do_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (do_push && !do_pop)      r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
    end
endmodule

/* hdl/dppc_front.sv */
// Front end: takes received bytes, tracks the message and classifies page commands
module dppc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  logic [7:0]      i_rx_byte,
    output dppc_pkg::t_cmd  o_push
);
    logic [dppc_pkg::CountW-1:0] r_count, n_count;
    logic [7:0] r_prior, n_prior;
    logic [7:0] r_h0, n_h0, r_h1, n_h1, r_k4, n_k4, r_k5, n_k5;
    logic       has_prior, term, ok_pair, head, key, clr;

    always_comb begin
        has_prior = (r_count != '0);
        n_h0 = (r_count == dppc_pkg::CountW'(0)) ? i_rx_byte : r_h0;
        n_h1 = (r_count == dppc_pkg::CountW'(1)) ? i_rx_byte : r_h1;
        n_k4 = (r_count == dppc_pkg::CountW'(4)) ? i_rx_byte : r_k4;
        n_k5 = (r_count == dppc_pkg::CountW'(5)) ? i_rx_byte : r_k5;
        term    = has_prior && (r_prior == dppc_pkg::TermPrior)
                  && (i_rx_byte == dppc_pkg::TermByte);
        ok_pair = has_prior && (r_prior == dppc_pkg::AsciiO)
                  && (i_rx_byte == dppc_pkg::AsciiK);
        head = (n_h0 == dppc_pkg::HeadFirst) && (n_h1 == dppc_pkg::HeadSecond)
               && (n_k4 == dppc_pkg::KeyHigh);
        key  = (n_k5 == dppc_pkg::KeyPage1) || (n_k5 == dppc_pkg::KeyPage0);
        o_push.valid = i_take && term && head && key;
        o_push.page  = (n_k5 == dppc_pkg::KeyPage1);
        // full buffer without terminator drops the message
        clr = term || ok_pair
              || (r_count >= dppc_pkg::CountW'(dppc_pkg::BufferDepth - 1));
        n_count = r_count + 1'b1;
        n_prior = i_rx_byte;
        if (clr) begin
            n_count = '0;
            n_prior = '0;
            n_h0    = '0;
            n_h1    = '0;
            n_k4    = '0;
            n_k5    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_prior <= '0;
            r_h0    <= '0;
            r_h1    <= '0;
            r_k4    <= '0;
            r_k5    <= '0;
        end else if (i_take) begin
            r_count <= n_count;
            r_prior <= n_prior;
            r_h0    <= n_h0;
            r_h1    <= n_h1;
            r_k4    <= n_k4;
            r_k5    <= n_k5;
        end
    end
endmodule

/* hdl/dppc_back.sv */
// Back end: sends the ten-byte page-switch frame for each queued command
module dppc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dppc_pkg::t_cmd  i_head,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_tx_byte,
    output logic            o_frame_end
);
    logic                       r_busy;
    logic [dppc_pkg::IdxW-1:0]  r_idx;
    logic                       r_page;
    logic                       last, done;

    assign last        = (r_idx == dppc_pkg::LastIdx);
    assign done        = r_busy && i_ready && last;
    assign o_pop       = i_head.valid && (!r_busy || done);
    assign o_valid     = r_busy;
    assign o_tx_byte   = dppc_pkg::frame_byte(r_idx, r_page);
    assign o_frame_end = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_page <= 1'b0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
            r_page <= i_head.page;
        end else if (done) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (r_busy && i_ready) begin
            r_idx  <= r_idx + 1'b1;
        end
    end
endmodule

/* hdl/display_page_command_parser.sv */
// Top level of the display page command parser
//
//  channel   valid     ready     payload
//  rx in     i_valid   o_ready   i_rx_byte
//  tx out    o_valid   i_ready   o_tx_byte, o_frame_end
//
// A received byte is taken while o_ready is high; o_ready drops only
// while the two-entry command queue is full. Each matched command gives
// ten frame bytes, one per cycle while i_ready is high. The sender pops
// the next command as a frame's last byte is taken. Reset is synchronous
// and clears message state, queue and sender; no clearing pass is needed.
module display_page_command_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_tx_byte,
    output logic       o_frame_end
);
    dppc_pkg::t_cmd push, head;
    logic           full, pop, take;

    assign o_ready = !full;
    assign take    = i_valid && o_ready;

    dppc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_rx_byte (i_rx_byte),
        .o_push    (push)
    );

    dppc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .o_head  (head),
        .i_pop   (pop)
    );

    dppc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_tx_byte   (o_tx_byte),
        .o_frame_end (o_frame_end)
    );
endmodule

/* hdl/dppc_checker.sv */
// Port checker for the display page command parser, with its bind
`include "display_page_command_parser_assert.svh"

module dppc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic [7:0] i_rx_byte,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_tx_byte,
    input logic       o_frame_end
);
    `DPPC_ASSERT(a_idle_after_reset, i_clk, i_rst_n, !$past(i_rst_n) |-> !o_valid)
    `DPPC_ASSERT(a_stall_holds, i_clk, i_rst_n, (o_valid && !i_ready) |=> (o_valid && $stable(o_tx_byte) && $stable(o_frame_end)))
    `DPPC_ASSERT(a_frame_restarts, i_clk, i_rst_n, (o_valid && i_ready && o_frame_end) |=> (!o_valid || o_tx_byte == 8'h5A))
    `DPPC_ASSERT(a_page_byte, i_clk, i_rst_n, (o_valid && o_frame_end) |-> (o_tx_byte == 8'h00 || o_tx_byte == 8'h01))
endmodule

bind display_page_command_parser dppc_checker u_dppc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .i_rx_byte   (i_rx_byte),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_tx_byte   (o_tx_byte),
    .o_frame_end (o_frame_end)
);

/* tb/tb_display_page_command_parser.sv */
// Self-checking testbench for the display page command parser: directed table, random messages
module tb_display_page_command_parser;

    localparam int MsgDepth    = 64;
    localparam int FrameLen    = 10;
    localparam int RandItems   = 100;
    localparam int LongHold    = 400;
    localparam int DrainCycles = 60;
    localparam int CycleLimit  = 200000;
    localparam int DirRows     = 23;

    localparam logic [7:0] HeadFirst  = 8'h5A;
    localparam logic [7:0] HeadSecond = 8'hA5;
    localparam logic [7:0] KeyHigh    = 8'h10;
    localparam logic [7:0] KeyPage1   = 8'h02;
    localparam logic [7:0] KeyPage0   = 8'h03;
    localparam logic [7:0] TermPrior  = 8'h01;
    localparam logic [7:0] TermByte   = 8'h00;
    localparam logic [7:0] AsciiO     = 8'h4F;
    localparam logic [7:0] AsciiK     = 8'h4B;

    // first nine bytes of every page-switch frame; the tenth is the page
    localparam logic [71:0] FrameHead = 72'h5AA5_0782_0084_5A01_00;

    typedef enum logic [1:0] {
        FRAME_NONE,
        FRAME_PAGE0,
        FRAME_PAGE1,
        FRAME_PREDICT
    } t_frame_kind;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_MOSTLY,
        SINK_COIN,
        SINK_SPARSE
    } t_sink_mode;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       frame_end;
    } t_tx_word;

    typedef struct packed {
        logic [7:0]  rx;
        t_frame_kind want;
    } t_dir_row;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic [7:0] i_rx_byte = 8'h00;
    logic       i_ready   = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_tx_byte;
    logic       o_frame_end;

    logic [6:0] msg_count;
    logic [7:0] prev_byte;
    logic [7:0] hdr_first;
    logic [7:0] hdr_second;
    logic [7:0] key_hi;
    logic [7:0] key_lo;

    t_tx_word   pending_tx_q [$];
    int         mismatches    = 0;
    int         cycle_count   = 0;
    int         burst_left    = 0;
    bit         long_hold_req = 1'b0;

    t_dir_row dir_rows [DirRows] = '{
        '{8'h00, FRAME_NONE},
        '{8'h4F, FRAME_PREDICT},
        '{8'h4B, FRAME_NONE},
        '{8'h5A, FRAME_PREDICT},
        '{8'hA5, FRAME_PREDICT},
        '{8'hFF, FRAME_PREDICT},
        '{8'hFF, FRAME_PREDICT},
        '{8'h10, FRAME_PREDICT},
        '{8'h02, FRAME_PREDICT},
        '{8'h01, FRAME_PREDICT},
        '{8'h00, FRAME_PAGE1},
        '{8'h5A, FRAME_PREDICT},
        '{8'hA5, FRAME_PREDICT},
        '{8'h00, FRAME_PREDICT},
        '{8'h80, FRAME_PREDICT},
        '{8'h10, FRAME_PREDICT},
        '{8'h03, FRAME_PREDICT},
        '{8'h01, FRAME_PREDICT},
        '{8'h00, FRAME_PAGE0},
        '{8'h5A, FRAME_PREDICT},
        '{8'hA5, FRAME_PREDICT},
        '{8'h01, FRAME_PREDICT},
        '{8'h00, FRAME_NONE}
    };

    display_page_command_parser DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_rx_byte   (i_rx_byte),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_tx_byte   (o_tx_byte),
        .o_frame_end (o_frame_end)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic void clear_msg();
        msg_count  = '0;
        prev_byte  = '0;
        hdr_first  = '0;
        hdr_second = '0;
        key_hi     = '0;
        key_lo     = '0;
    endfunction

    function automatic t_frame_kind parse_rx_byte(input logic [7:0] b);
        logic [6:0]  pos;
        logic        has_prev;
        logic        head_ok;
        t_frame_kind kind;
        pos      = msg_count;
        has_prev = (pos != '0);
        kind     = FRAME_NONE;
        if (pos == 7'd0) hdr_first = b;
        else if (pos == 7'd1) hdr_second = b;
        else if (pos == 7'd4) key_hi = b;
        else if (pos == 7'd5) key_lo = b;
        msg_count = pos + 7'd1;
        if (has_prev && prev_byte == TermPrior && b == TermByte) begin
            head_ok = (hdr_first == HeadFirst) && (hdr_second == HeadSecond);
            if (head_ok && key_hi == KeyHigh && key_lo == KeyPage1) kind = FRAME_PAGE1;
            else if (head_ok && key_hi == KeyHigh && key_lo == KeyPage0) kind = FRAME_PAGE0;
            clear_msg();
        end else if (has_prev && prev_byte == AsciiO && b == AsciiK) begin
            clear_msg();
        end else begin
            prev_byte = b;
            if (int'(msg_count) >= MsgDepth) clear_msg();
        end
        return kind;
    endfunction

    function automatic void queue_frame(input t_frame_kind kind);
        t_tx_word w;
        if (kind == FRAME_NONE || kind == FRAME_PREDICT) return;
        for (int i = 0; i < FrameLen; i++) begin
            if (i == FrameLen - 1) w.tx_byte = {7'd0, kind == FRAME_PAGE1};
            else w.tx_byte = FrameHead[71 - 8 * i -: 8];
            w.frame_end = (i == FrameLen - 1);
            pending_tx_q.push_back(w);
        end
    endfunction

    // one request: bursts with random gaps, valid held until taken
    task automatic offer_byte(input logic [7:0] b, input t_frame_kind want);
        int          gap;
        t_frame_kind kind;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 7);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        burst_left--;
        kind = parse_rx_byte(b);
        queue_frame((want == FRAME_PREDICT) ? kind : want);
    endtask

    initial begin : stimulus
        logic [7:0] msg [$];
        logic [7:0] b;
        int         rand_sent;
        int         msg_idx;
        int         pick;
        rand_sent = 0;
        msg_idx   = 0;
        clear_msg();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) offer_byte(dir_rows[r].rx, dir_rows[r].want);

        long_hold_req = 1'b1;
        while (rand_sent < RandItems) begin
            msg.delete();
            pick = (msg_idx < 4) ? 0 : (msg_idx == 4) ? 10 : $urandom_range(0, 9);
            msg.push_back(AsciiO);
            msg.push_back(AsciiK);
            if (pick <= 5) begin
                msg.push_back(HeadFirst);
                msg.push_back(HeadSecond);
                msg.push_back(8'($urandom));
                msg.push_back(8'($urandom));
                msg.push_back(KeyHigh);
                msg.push_back($urandom_range(0, 1) ? KeyPage1 : KeyPage0);
                repeat ($urandom_range(0, 3)) msg.push_back(8'($urandom));
                msg.push_back(TermPrior);
                msg.push_back(TermByte);
                if (pick == 5) msg[$urandom_range(2, msg.size() - 1)] = 8'($urandom);
            end else if (pick == 6) begin
                repeat ($urandom_range(1, 6)) msg.push_back(8'($urandom));
            end else if (pick == 7) begin
                msg.push_back(AsciiO);
                msg.push_back($urandom_range(0, 1) ? AsciiK : 8'($urandom));
            end else if (pick == 8) begin
                repeat ($urandom_range(0, 6)) msg.push_back(8'($urandom));
                msg.push_back(TermPrior);
                msg.push_back(TermByte);
            end else if (pick == 9) begin
                repeat ($urandom_range(2, 10)) begin
                    case ($urandom_range(0, 6))
                        0: msg.push_back(TermPrior);
                        1: msg.push_back(TermByte);
                        2: msg.push_back(AsciiO);
                        3: msg.push_back(AsciiK);
                        4: msg.push_back(HeadFirst);
                        5: msg.push_back(KeyHigh);
                        default: msg.push_back(8'($urandom));
                    endcase
                end
            end else begin
                // overrun the message store with no terminator in sight
                repeat (MsgDepth + 6) begin
                    b = 8'($urandom);
                    if (b == TermPrior || b == AsciiO) b = b + 8'h02;
                    msg.push_back(b);
                end
            end
            foreach (msg[k]) offer_byte(msg[k], FRAME_PREDICT);
            rand_sent += msg.size();
            msg_idx++;
        end
        i_valid <= 1'b0;

        while (pending_tx_q.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin : tx_sink
        t_sink_mode mode;
        int         span;
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (LongHold) @(posedge i_clk);
            end
            mode = t_sink_mode'($urandom_range(0, 3));
            span = $urandom_range(8, 48);
            repeat (span) begin
                if (long_hold_req) break;
                case (mode)
                    SINK_OPEN:   i_ready <= 1'b1;
                    SINK_MOSTLY: i_ready <= ($urandom_range(0, 3) != 0);
                    SINK_COIN:   i_ready <= 1'($urandom_range(0, 1));
                    default:     i_ready <= ($urandom_range(0, 4) == 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : tx_check
        t_tx_word w;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_tx_q.size() == 0) begin
                $error("tx_byte: nothing expected, got %02h", o_tx_byte);
                mismatches++;
            end else begin
                w = pending_tx_q.pop_front();
                if (o_tx_byte !== w.tx_byte) begin
                    $error("tx_byte: expected %02h, got %02h", w.tx_byte, o_tx_byte);
                    mismatches++;
                end
                if (o_frame_end !== w.frame_end) begin
                    $error("frame_end: expected %0b, got %0b", w.frame_end, o_frame_end);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/dppc_pkg.sv
hdl/dppc_queue.sv
hdl/dppc_front.sv
hdl/dppc_back.sv
hdl/display_page_command_parser.sv
hdl/dppc_checker.sv
tb/tb_display_page_command_parser.sv
